>>> sv/lr35_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr35_pkg
// Types and operation codes shared by the eight-bit ALU with flags and HL.
// ----------------------------------------------------------------------------
package lr35_pkg;

    // operation codes carried in the action field
    localparam logic [3:0] ACT_ADD    = 4'd0;
    localparam logic [3:0] ACT_ADC    = 4'd1;
    localparam logic [3:0] ACT_SUB    = 4'd2;
    localparam logic [3:0] ACT_SBC    = 4'd3;
    localparam logic [3:0] ACT_AND    = 4'd4;
    localparam logic [3:0] ACT_XOR    = 4'd5;
    localparam logic [3:0] ACT_OR     = 4'd6;
    localparam logic [3:0] ACT_CP     = 4'd7;
    localparam logic [3:0] ACT_DAA    = 4'd8;
    localparam logic [3:0] ACT_CPL    = 4'd9;
    localparam logic [3:0] ACT_SCF    = 4'd10;
    localparam logic [3:0] ACT_CCF    = 4'd11;
    localparam logic [3:0] ACT_ADD_HL = 4'd12;
    localparam logic [3:0] ACT_BIT    = 4'd13;

    // decimal adjust constants
    localparam logic [7:0] DAA_ADJ_LO = 8'h06;
    localparam logic [7:0] DAA_ADJ_HI = 8'h60;
    localparam logic [7:0] DAA_MAX_HI = 8'h99;
    localparam logic [3:0] DAA_MAX_LO = 4'h9;

    // one request
    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  operand;
        logic [15:0] operand_wide;
        logic [2:0]  bit_index;
    } t_in_item;

    // one result
    typedef struct packed {
        logic [7:0]  acc_out;
        logic        zero_flag;
        logic        subtract_flag;
        logic        half_carry_flag;
        logic        carry_flag;
        logic [15:0] hl_out;
    } t_out_item;

    // architectural state: accumulator, flags, HL
    typedef struct packed {
        logic [7:0]  acc;
        logic        z;
        logic        n;
        logic        h;
        logic        c;
        logic [15:0] hl;
    } t_state;

endpackage
`default_nettype wire

>>> sv/lr35902_alu_with_flags.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr35902_alu_with_flags
// Eight-bit ALU with accumulator, Z/N/H/C flags and HL pair kept inside.
// ----------------------------------------------------------------------------
// path: an accepted request is loaded into the input register, then executed
//   into the result register and the kept state together once the result
//   register is free or being drained
// throughput: one request per cycle while the output is not stalled, set by the single execute stage
// reset: synchronous active low; clears accumulator, flags, HL and both
//   valid bits
module lr35902_alu_with_flags (
    input  var logic                i_clk,
    input  var logic                i_rst_n,
    input  var logic                i_in_valid,
    output logic                    o_in_ready,
    input  var lr35_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  var logic                i_out_ready,
    output lr35_pkg::t_out_item     o_out_data
);

    logic                r_in_valid;
    lr35_pkg::t_in_item  r_in;
    logic                r_out_valid;
    lr35_pkg::t_out_item r_out;
    lr35_pkg::t_state    r_state;
    lr35_pkg::t_state    n_state;
    logic                advance;

    // execute stage moves when the result register is free or being drained
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // execute
    lr35_alu u_alu (
        .i_item  (r_in),
        .i_state (r_state),
        .o_state (n_state)
    );

    // kept state and result register update together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (advance && r_in_valid) begin
            r_out.acc_out         <= n_state.acc;
            r_out.zero_flag       <= n_state.z;
            r_out.subtract_flag   <= n_state.n;
            r_out.half_carry_flag <= n_state.h;
            r_out.carry_flag      <= n_state.c;
            r_out.hl_out          <= n_state.hl;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

    // a shown result's accumulator, HL and carry always match the kept state
    a_out_is_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.acc_out == r_state.acc) &&
                        (r_out.hl_out == r_state.hl) &&
                        (r_out.carry_flag == r_state.c))
        else $error("result differs from kept state");

    // an executed request always produces a result next cycle
    a_exec_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance |=> r_out_valid)
        else $error("executed request lost");

    // set carry leaves carry high with N and H clear
    a_scf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && advance && (r_in.action == lr35_pkg::ACT_SCF)
        |=> r_state.c && !r_state.n && !r_state.h)
        else $error("set carry flags wrong");

endmodule
`default_nettype wire

>>> sv/lr35_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lr35_alu
// Combinational execute unit: next accumulator, flags and HL for one request.
// ----------------------------------------------------------------------------
module lr35_alu (
    input  var lr35_pkg::t_in_item i_item,
    input  var lr35_pkg::t_state   i_state,
    output lr35_pkg::t_state       o_state
);

    logic       cin;
    logic [8:0] add_sum;
    logic [4:0] add_half;
    logic [8:0] sub_diff;
    logic [4:0] sub_half;
    logic [7:0] and_res;
    logic [7:0] xor_res;
    logic [7:0] or_res;
    logic       daa_c;
    logic [7:0] daa_adj;
    logic [7:0] daa_res;
    logic [16:0] hl_sum;
    logic [12:0] hl_half;

    // carry in only for the with-carry forms
    assign cin = ((i_item.action == lr35_pkg::ACT_ADC) ||
                  (i_item.action == lr35_pkg::ACT_SBC)) ? i_state.c : 1'b0;

    // eight-bit add and subtract with nibble carry / borrow
    assign add_sum  = {1'b0, i_state.acc} + {1'b0, i_item.operand} + {8'd0, cin};
    assign add_half = {1'b0, i_state.acc[3:0]} + {1'b0, i_item.operand[3:0]}
                      + {4'd0, cin};
    assign sub_diff = {1'b0, i_state.acc} - {1'b0, i_item.operand} - {8'd0, cin};
    assign sub_half = {1'b0, i_state.acc[3:0]} - {1'b0, i_item.operand[3:0]}
                      - {4'd0, cin};

    // logic group
    assign and_res = i_state.acc & i_item.operand;
    assign xor_res = i_state.acc ^ i_item.operand;
    assign or_res  = i_state.acc | i_item.operand;

    // decimal adjust, tests on the unadjusted accumulator
    always_comb begin
        daa_c   = i_state.c;
        daa_adj = 8'd0;
        if (!i_state.n) begin
            if (i_state.c || (i_state.acc > lr35_pkg::DAA_MAX_HI)) begin
                daa_adj = daa_adj | lr35_pkg::DAA_ADJ_HI;
                daa_c   = 1'b1;
            end
            if (i_state.h || (i_state.acc[3:0] > lr35_pkg::DAA_MAX_LO)) begin
                daa_adj = daa_adj | lr35_pkg::DAA_ADJ_LO;
            end
            daa_res = i_state.acc + daa_adj;
        end else begin
            if (i_state.c) begin
                daa_adj = daa_adj | lr35_pkg::DAA_ADJ_HI;
            end
            if (i_state.h) begin
                daa_adj = daa_adj | lr35_pkg::DAA_ADJ_LO;
            end
            daa_res = i_state.acc - daa_adj;
        end
    end

    // sixteen-bit add to HL
    assign hl_sum  = {1'b0, i_state.hl} + {1'b0, i_item.operand_wide};
    assign hl_half = {1'b0, i_state.hl[11:0]} + {1'b0, i_item.operand_wide[11:0]};

    // operation select
    always_comb begin
        o_state = i_state;
        unique case (i_item.action)
            lr35_pkg::ACT_ADD, lr35_pkg::ACT_ADC: begin
                o_state.acc = add_sum[7:0];
                o_state.z   = (add_sum[7:0] == 8'd0);
                o_state.n   = 1'b0;
                o_state.h   = add_half[4];
                o_state.c   = add_sum[8];
            end
            lr35_pkg::ACT_SUB, lr35_pkg::ACT_SBC, lr35_pkg::ACT_CP: begin
                if (i_item.action != lr35_pkg::ACT_CP) begin
                    o_state.acc = sub_diff[7:0];
                end
                o_state.z = (sub_diff[7:0] == 8'd0);
                o_state.n = 1'b1;
                o_state.h = sub_half[4];
                o_state.c = sub_diff[8];
            end
            lr35_pkg::ACT_AND: begin
                o_state.acc = and_res;
                o_state.z   = (and_res == 8'd0);
                o_state.n   = 1'b0;
                o_state.h   = 1'b1;
                o_state.c   = 1'b0;
            end
            lr35_pkg::ACT_XOR: begin
                o_state.acc = xor_res;
                o_state.z   = (xor_res == 8'd0);
                o_state.n   = 1'b0;
                o_state.h   = 1'b0;
                o_state.c   = 1'b0;
            end
            lr35_pkg::ACT_OR: begin
                o_state.acc = or_res;
                o_state.z   = (or_res == 8'd0);
                o_state.n   = 1'b0;
                o_state.h   = 1'b0;
                o_state.c   = 1'b0;
            end
            lr35_pkg::ACT_DAA: begin
                o_state.acc = daa_res;
                o_state.z   = (daa_res == 8'd0);
                o_state.h   = 1'b0;
                o_state.c   = daa_c;
            end
            lr35_pkg::ACT_CPL: begin
                o_state.acc = ~i_state.acc;
                o_state.n   = 1'b1;
                o_state.h   = 1'b1;
            end
            lr35_pkg::ACT_SCF: begin
                o_state.n = 1'b0;
                o_state.h = 1'b0;
                o_state.c = 1'b1;
            end
            lr35_pkg::ACT_CCF: begin
                o_state.n = 1'b0;
                o_state.h = 1'b0;
                o_state.c = ~i_state.c;
            end
            lr35_pkg::ACT_ADD_HL: begin
                o_state.hl = hl_sum[15:0];
                o_state.n  = 1'b0;
                o_state.h  = hl_half[12];
                o_state.c  = hl_sum[16];
            end
            lr35_pkg::ACT_BIT: begin
                o_state.z = ~i_item.operand[i_item.bit_index];
                o_state.n = 1'b0;
                o_state.h = 1'b1;
            end
            default: begin
                // unused codes leave the state alone
                o_state = i_state;
            end
        endcase
    end

endmodule
`default_nettype wire
